// ===== rtl/core/mrp_pkg.sv =====
// ----------------------------------------------------------------------------
// mrp_pkg: shared types and constants of the MADT record parser
// Record codes, result kinds, sizes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package mrp_pkg;

	// Capacity limits.
	localparam int MAX_PROCESSORS     = 64;
	localparam int MAX_IO_CONTROLLERS = 8;

	localparam int PROC_AW  = (MAX_PROCESSORS > 1) ? $clog2(MAX_PROCESSORS) : 1;
	localparam int PROC_CW  = $clog2(MAX_PROCESSORS + 1);
	localparam int IOCTL_CW = $clog2(MAX_IO_CONTROLLERS + 1);

	// Table layout.
	localparam logic [3:0] HDR_BYTES = 4'd8;
	localparam int         REC_DEPTH = 16;

	// Record type codes.
	localparam logic [7:0] REC_LAPIC    = 8'd0;
	localparam logic [7:0] REC_IOAPIC   = 8'd1;
	localparam logic [7:0] REC_BASE_OVR = 8'd5;
	localparam logic [7:0] REC_X2APIC   = 8'd9;

	// Minimum record lengths.
	localparam logic [7:0] LEN_MIN    = 8'd2;
	localparam logic [7:0] LEN_LAPIC  = 8'd8;
	localparam logic [7:0] LEN_IOAPIC = 8'd12;
	localparam logic [7:0] LEN_BASE   = 8'd12;
	localparam logic [7:0] LEN_X2APIC = 8'd16;

	// Result kinds.
	localparam logic [1:0] KIND_PROC    = 2'd0;
	localparam logic [1:0] KIND_IOCTL   = 2'd1;
	localparam logic [1:0] KIND_SUMMARY = 2'd2;

	localparam int PROC_TOTAL_W = 7;
	localparam int RES_BITS     = 32 + 32 + 1 + 64 + 32 + 32 + PROC_TOTAL_W + 1;
	localparam int TDATA_W      = ((RES_BITS + 7) / 8) * 8;

	typedef struct packed {
		logic [1:0]              kind;
		logic [31:0]             proc_id;
		logic [31:0]             proc_uid;
		logic                    wide_mode;
		logic [63:0]             base_address;
		logic [31:0]             first_irq_line;
		logic [31:0]             table_flags;
		logic [PROC_TOTAL_W-1:0] proc_total;
		logic                    table_ok;
		logic                    last;
	} result_t;

	// Controller to datapath.
	typedef struct packed {
		logic capture;
		logic step;
		logic scan_start;
		logic scan_run;
		logic apply_base;
		logic load_proc;
		logic load_io;
		logic load_sum;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic fin;
		logic end_tbl;
		logic proc_cand;
		logic io_cand;
		logic base_rec;
		logic scan_done;
		logic dup;
		logic slot_free;
	} status_t;

endpackage

// ===== rtl/core/madt_record_parser.sv =====
// ----------------------------------------------------------------------------
// madt_record_parser: streaming parser for the interrupt-controller table body
// Emits processor, I/O controller and end-of-table summary results.
// ----------------------------------------------------------------------------
// Usage. The table body (after the common 36-byte header) enters one byte per
// beat on the s_axis channel, with s_axis_tlast on the final byte of the
// table. The first eight bytes are the local controller base and the table
// flags; type/length records follow. Results leave on the m_axis channel:
// a processor entry when an enabled processor record with a new id ends and
// the id store has room, an I/O controller entry when an I/O record ends
// below the controller limit, and a summary on the final byte. A record that
// ends on the final byte gives its entry first, then the summary; m_axis_tlast
// marks the final result caused by an input byte. Each byte is accepted, then
// updates the parse state, then is decided on. At the end of a processor
// record the id memory is scanned at one entry per cycle, and each emitted
// result is loaded into the output register, which lets the next byte be
// accepted while a result waits. If the receiver stalls with the register
// full, the parser holds at its next result and s_axis_tready stays low
// until it is taken.
// After reset, and after each summary, all counts and the id store are empty
// and the next byte starts a new table.
// ----------------------------------------------------------------------------
module madt_record_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// data_byte [7:0]
	input  logic [7:0]                  s_axis_tdata,
	input  logic                        s_axis_tlast,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// proc_id [31:0], proc_uid [63:32], wide_mode [64], base_address [128:65],
	// first_irq_line [160:129], table_flags [192:161], proc_total [199:193],
	// table_ok [200], zero padding above
	output logic [mrp_pkg::TDATA_W-1:0] m_axis_tdata,
	// kind [1:0]
	output logic [1:0]                  m_axis_tuser,
	output logic                        m_axis_tlast
);
	import mrp_pkg::*;

	localparam int PAD_W = TDATA_W - RES_BITS;

	cmd_t    cmd;
	status_t st;
	result_t res;

	mrp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	mrp_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (s_axis_tdata),
		.in_end    (s_axis_tlast),
		.cmd       (cmd),
		.st        (st),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_res   (res)
	);

	// Pack the result fields, lowest field first.
	assign m_axis_tdata = {{PAD_W{1'b0}}, res.table_ok, res.proc_total, res.table_flags,
		res.first_irq_line, res.base_address, res.wide_mode, res.proc_uid, res.proc_id};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;

endmodule

// ===== rtl/core/mrp_datapath.sv =====
// ----------------------------------------------------------------------------
// mrp_datapath: parse state, record buffer, processor id store and result
// Holds the header words, the current record, the id memory with its
// duplicate scan, and the output register.
// ----------------------------------------------------------------------------
module mrp_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       in_byte,
	input  logic             in_end,
	input  mrp_pkg::cmd_t    cmd,
	output mrp_pkg::status_t st,
	input  logic             out_ready,
	output logic             out_valid,
	output mrp_pkg::result_t out_res
);
	import mrp_pkg::*;

	logic [7:0]         byte_q;
	logic               end_q;
	logic [7:0]         rec_q [REC_DEPTH];
	logic [31:0]        proc_mem [MAX_PROCESSORS];
	logic [31:0]        rd_data_s1;
	logic               pend_s1;
	logic [PROC_CW-1:0] scan_idx_q;
	logic               dup_q;

	logic [PROC_CW-1:0]  proc_count_q;
	logic [IOCTL_CW-1:0] ioctl_count_q;
	logic [63:0]         local_base_q;
	logic [31:0]         flags_q;
	logic [3:0]          body_pos_q;
	logic [7:0]          rp_q;
	logic [7:0]          len_q;
	logic                err_q;
	logic                fin_q;
	logic                out_valid_q;
	result_t             res_q;
	result_t             res_nxt;

	logic        hdr;
	logic [3:0]  body_pos_nxt;
	logic [8:0]  cnt;
	logic [7:0]  len_now;
	logic        bad_len;
	logic        rec_done;
	logic [7:0]  rec_type;
	logic        wide;
	logic [31:0] cand_id;
	logic [31:0] cand_uid;
	logic [31:0] rec_w4;
	logic [31:0] rec_w8;
	logic        scan_more;
	logic        room;

	assign hdr          = body_pos_q < HDR_BYTES;
	assign body_pos_nxt = body_pos_q + 4'd1;
	assign cnt          = {1'b0, rp_q} + 9'd1;
	assign len_now      = (rp_q == 8'd1) ? byte_q : len_q;
	assign bad_len      = (rp_q == 8'd1) && (byte_q < LEN_MIN);
	assign rec_done     = (rp_q != 8'd0) && (cnt == {1'b0, len_now});

	assign rec_type = rec_q[0];
	assign wide     = rec_type == REC_X2APIC;
	assign rec_w4   = {rec_q[7], rec_q[6], rec_q[5], rec_q[4]};
	assign rec_w8   = {rec_q[11], rec_q[10], rec_q[9], rec_q[8]};
	assign cand_id  = wide ? rec_w4 : {24'd0, rec_q[3]};
	assign cand_uid = wide ? {rec_q[15], rec_q[14], rec_q[13], rec_q[12]} : {24'd0, rec_q[2]};

	assign room      = proc_count_q < PROC_CW'(MAX_PROCESSORS);
	assign scan_more = scan_idx_q < proc_count_q;

	assign st.fin       = fin_q;
	assign st.end_tbl   = end_q;
	assign st.proc_cand = room && (((rec_type == REC_LAPIC) && (len_q >= LEN_LAPIC) && rec_q[4][0])
		|| ((rec_type == REC_X2APIC) && (len_q >= LEN_X2APIC) && rec_q[8][0]));
	assign st.io_cand   = (rec_type == REC_IOAPIC) && (len_q >= LEN_IOAPIC)
		&& (ioctl_count_q < IOCTL_CW'(MAX_IO_CONTROLLERS));
	assign st.base_rec  = (rec_type == REC_BASE_OVR) && (len_q >= LEN_BASE);
	assign st.scan_done = !scan_more && !pend_s1;
	assign st.dup       = dup_q;
	assign st.slot_free = !out_valid_q || out_ready;

	// Next result, with every field outside its kind held at zero.
	always_comb begin
		res_nxt = '0;
		if (cmd.load_sum) begin
			res_nxt.kind         = KIND_SUMMARY;
			res_nxt.base_address = local_base_q;
			res_nxt.table_flags  = flags_q;
			res_nxt.proc_total   = PROC_TOTAL_W'(proc_count_q);
			res_nxt.table_ok     = !err_q && (proc_count_q != '0) && (local_base_q != 64'd0);
			res_nxt.last         = 1'b1;
		end else if (cmd.load_io) begin
			res_nxt.kind           = KIND_IOCTL;
			res_nxt.proc_id        = {24'd0, rec_q[2]};
			res_nxt.base_address   = {32'd0, rec_w4};
			res_nxt.first_irq_line = rec_w8;
			res_nxt.last           = !end_q;
		end else begin
			res_nxt.kind      = KIND_PROC;
			res_nxt.proc_id   = cand_id;
			res_nxt.proc_uid  = cand_uid;
			res_nxt.wide_mode = wide;
			res_nxt.last      = !end_q;
		end
	end

	// Payload storage: input byte, record buffer, id memory, result.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			byte_q <= in_byte;
			end_q  <= in_end;
		end
		if (cmd.step && !err_q && !hdr && (rp_q < 8'(REC_DEPTH)))
			rec_q[rp_q[3:0]] <= byte_q;
		if (cmd.load_proc)
			proc_mem[proc_count_q[PROC_AW-1:0]] <= cand_id;
		if (cmd.scan_run && scan_more)
			rd_data_s1 <= proc_mem[scan_idx_q[PROC_AW-1:0]];
		if (cmd.load_proc || cmd.load_io || cmd.load_sum)
			res_q <= res_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proc_count_q  <= '0;
			ioctl_count_q <= '0;
			local_base_q  <= '0;
			flags_q       <= '0;
			body_pos_q    <= '0;
			rp_q          <= '0;
			len_q         <= '0;
			err_q         <= 1'b0;
			fin_q         <= 1'b0;
			out_valid_q   <= 1'b0;
			scan_idx_q    <= '0;
			pend_s1       <= 1'b0;
			dup_q         <= 1'b0;
		end else begin
			if (cmd.step) begin
				fin_q <= 1'b0;
				if (!err_q) begin
					if (hdr) begin
						if (!body_pos_q[2])
							local_base_q[{body_pos_q[1:0], 3'b000} +: 8] <= byte_q;
						else
							flags_q[{body_pos_q[1:0], 3'b000} +: 8] <= byte_q;
						body_pos_q <= body_pos_nxt;
						if (end_q && (body_pos_nxt < HDR_BYTES))
							err_q <= 1'b1;
					end else begin
						if (rp_q == 8'd1)
							len_q <= byte_q;
						if (bad_len) begin
							err_q <= 1'b1;
						end else if (rec_done) begin
							rp_q  <= '0;
							fin_q <= 1'b1;
						end else begin
							rp_q <= cnt[7:0];
							if (end_q)
								err_q <= 1'b1;
						end
					end
				end
			end

			if (cmd.apply_base)
				local_base_q <= {rec_w8, rec_w4};

			if (cmd.scan_start) begin
				scan_idx_q <= '0;
				pend_s1    <= 1'b0;
				dup_q      <= 1'b0;
			end else if (cmd.scan_run) begin
				pend_s1 <= scan_more;
				if (scan_more)
					scan_idx_q <= scan_idx_q + PROC_CW'(1);
				if (pend_s1 && (rd_data_s1 == cand_id))
					dup_q <= 1'b1;
			end

			if (cmd.load_proc)
				proc_count_q <= proc_count_q + PROC_CW'(1);
			if (cmd.load_io)
				ioctl_count_q <= ioctl_count_q + IOCTL_CW'(1);

			// The summary closes the table: everything starts afresh.
			if (cmd.load_sum) begin
				proc_count_q  <= '0;
				ioctl_count_q <= '0;
				local_base_q  <= '0;
				flags_q       <= '0;
				body_pos_q    <= '0;
				rp_q          <= '0;
				len_q         <= '0;
				err_q         <= 1'b0;
			end

			if (cmd.load_proc || cmd.load_io || cmd.load_sum)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

endmodule

// ===== rtl/core/mrp_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrp_ctrl: sequencing of the MADT record parser
// Walks each body byte through update, decision, duplicate scan and emission.
// ----------------------------------------------------------------------------
module mrp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  mrp_pkg::status_t st,
	output mrp_pkg::cmd_t    cmd
);
	import mrp_pkg::*;

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_STEP      = 3'd1;
	localparam logic [2:0] S_DECIDE    = 3'd2;
	localparam logic [2:0] S_SCAN      = 3'd3;
	localparam logic [2:0] S_EMIT_PROC = 3'd4;
	localparam logic [2:0] S_EMIT_IO   = 3'd5;
	localparam logic [2:0] S_SUM       = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic [2:0] after_rec;

	assign in_ready  = state_q == S_IDLE;
	assign after_rec = st.end_tbl ? S_SUM : S_IDLE;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid)
					state_nxt = S_STEP;
			end
			S_STEP: begin
				cmd.step  = 1'b1;
				state_nxt = S_DECIDE;
			end
			S_DECIDE: begin
				state_nxt = after_rec;
				if (st.fin) begin
					if (st.proc_cand) begin
						cmd.scan_start = 1'b1;
						state_nxt      = S_SCAN;
					end else if (st.io_cand) begin
						state_nxt = S_EMIT_IO;
					end else if (st.base_rec) begin
						cmd.apply_base = 1'b1;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (st.scan_done)
					state_nxt = st.dup ? after_rec : S_EMIT_PROC;
			end
			S_EMIT_PROC: begin
				if (st.slot_free) begin
					cmd.load_proc = 1'b1;
					state_nxt     = after_rec;
				end
			end
			S_EMIT_IO: begin
				if (st.slot_free) begin
					cmd.load_io = 1'b1;
					state_nxt   = after_rec;
				end
			end
			S_SUM: begin
				if (st.slot_free) begin
					cmd.load_sum = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for madt_record_parser
// Streams table bodies a byte per beat and holds its own running model of the
// parser, which predicts the processor, I/O controller and summary entries
// for every accepted byte. Each entry that leaves the parser is checked
// against the oldest prediction. Directed tables come first, then random
// ones, with random gaps on both channels and a long receiver stall.
// ----------------------------------------------------------------------------
module tb;
	import mrp_pkg::*;

	localparam int MAX_WAIT      = 18;
	localparam int SETTLE_CYCLES = 200;
	localparam int TIMEOUT_NS    = 4_000_000;
	localparam int RANDOM_BYTES  = 600;

	typedef enum int {IDLE_NONE, IDLE_SPARSE, IDLE_FULL} idle_mode_e;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata  = 8'h00;
	logic                s_axis_tlast  = 1'b0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [TDATA_W-1:0]  m_axis_tdata;
	logic [1:0]          m_axis_tuser;
	logic                m_axis_tlast;

	madt_record_parser DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #2 clk = ~clk;

	// Shared between the stimulus, the sink and the checker.
	idle_mode_e  tx_mode      = IDLE_FULL;
	idle_mode_e  rx_mode      = IDLE_FULL;
	int          rx_hold_req  = 0;
	bit          result_taken = 1'b0;
	int          mismatches   = 0;
	result_t     results_due[$];
	logic [7:0]  tbl_bytes[$];

	// Running image of the parser: header fields, the record being gathered,
	// the processor ids stored so far and the I/O controller count.
	logic [63:0] tbl_base;
	logic [31:0] tbl_flags;
	int          hdr_pos;
	logic [7:0]  rec_buf [16];
	logic [7:0]  rec_pos;
	logic [7:0]  rec_len;
	bit          parse_err;
	logic [31:0] cpu_ids[$];
	int          ioc_count;

	function automatic void clear_parse_state();
		tbl_base  = '0;
		tbl_flags = '0;
		hdr_pos   = 0;
		foreach (rec_buf[i])
			rec_buf[i] = '0;
		rec_pos   = '0;
		rec_len   = '0;
		parse_err = 1'b0;
		cpu_ids.delete();
		ioc_count = 0;
	endfunction

	function automatic logic [31:0] rec_word(int at);
		return {rec_buf[at+3], rec_buf[at+2], rec_buf[at+1], rec_buf[at]};
	endfunction

	// Acts on a record whose last byte has just arrived. Returns 1 when the
	// record gives an entry of its own.
	function automatic bit close_record(output result_t r);
		logic [31:0] id;
		logic [31:0] uid;
		logic [31:0] flags;
		bit          wide;
		r = '0;
		if (rec_buf[0] == REC_LAPIC && rec_len >= LEN_LAPIC) begin
			id    = {24'h0, rec_buf[3]};
			uid   = {24'h0, rec_buf[2]};
			flags = rec_word(4);
			wide  = 1'b0;
		end else if (rec_buf[0] == REC_X2APIC && rec_len >= LEN_X2APIC) begin
			id    = rec_word(4);
			flags = rec_word(8);
			uid   = rec_word(12);
			wide  = 1'b1;
		end else begin
			if (rec_buf[0] == REC_IOAPIC && rec_len >= LEN_IOAPIC &&
			    ioc_count < MAX_IO_CONTROLLERS) begin
				ioc_count++;
				r.kind           = KIND_IOCTL;
				r.proc_id        = {24'h0, rec_buf[2]};
				r.base_address   = {32'h0, rec_word(4)};
				r.first_irq_line = rec_word(8);
				return 1'b1;
			end
			if (rec_buf[0] == REC_BASE_OVR && rec_len >= LEN_BASE)
				tbl_base = {rec_word(8), rec_word(4)};
			return 1'b0;
		end
		// A processor is kept only when enabled, new and there is room.
		if (!flags[0] || cpu_ids.size() >= MAX_PROCESSORS)
			return 1'b0;
		foreach (cpu_ids[i])
			if (cpu_ids[i] == id)
				return 1'b0;
		cpu_ids.push_back(id);
		r.kind      = KIND_PROC;
		r.proc_id   = id;
		r.proc_uid  = uid;
		r.wide_mode = wide;
		return 1'b1;
	endfunction

	// Advances the running image by one accepted byte and queues the entries
	// that the byte causes, record entry first and summary last.
	function automatic void predict_byte(logic [7:0] b, bit eot);
		result_t     r;
		result_t     s;
		bit          have_rec;
		logic [8:0]  cnt;
		have_rec = 1'b0;
		r        = '0;
		if (!parse_err) begin
			if (hdr_pos < HDR_BYTES) begin
				if (hdr_pos < 4)
					tbl_base[8*hdr_pos +: 8] = b;
				else
					tbl_flags[8*(hdr_pos-4) +: 8] = b;
				hdr_pos++;
				if (eot && hdr_pos < HDR_BYTES)
					parse_err = 1'b1;
			end else begin
				cnt = {1'b0, rec_pos} + 9'd1;
				if (rec_pos < REC_DEPTH)
					rec_buf[rec_pos] = b;
				if (rec_pos == 8'd1) begin
					rec_len = b;
					if (b < LEN_MIN)
						parse_err = 1'b1;
				end
				if (!parse_err && rec_pos >= 8'd1 && cnt == {1'b0, rec_len}) begin
					rec_pos  = '0;
					have_rec = close_record(r);
				end else if (!parse_err) begin
					rec_pos = cnt[7:0];
					if (eot)
						parse_err = 1'b1;
				end
			end
		end
		if (have_rec) begin
			r.last = !eot;
			results_due.push_back(r);
		end
		if (eot) begin
			s              = '0;
			s.kind         = KIND_SUMMARY;
			s.base_address = tbl_base;
			s.table_flags  = tbl_flags;
			s.proc_total   = PROC_TOTAL_W'(cpu_ids.size());
			s.table_ok     = !parse_err && cpu_ids.size() != 0 && tbl_base != '0;
			s.last         = 1'b1;
			results_due.push_back(s);
			clear_parse_state();
		end
	endfunction

	function automatic int draw_wait(idle_mode_e m);
		case (m)
			IDLE_NONE:   return 0;
			IDLE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_WAIT) : 0;
			default:     return $urandom_range(0, MAX_WAIT);
		endcase
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Offers one byte after a drawn gap and waits for its beat. The valid
	// stays high once raised, so back-to-back bytes see no bubble.
	task automatic send_byte(input logic [7:0] b, input bit eot);
		int gap;
		gap = draw_wait(tx_mode);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= eot;
		do
			@(posedge clk);
		while (!s_axis_tready);
		predict_byte(b, eot);
	endtask

	task automatic send_table();
		int n;
		n = tbl_bytes.size();
		for (int i = 0; i < n; i++)
			send_byte(tbl_bytes[i], i == n - 1);
		tbl_bytes.delete();
	endtask

	// Stops offering and waits until every predicted entry has been taken.
	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
	endtask

	// Table building: every helper appends to tbl_bytes, little-endian.
	task automatic put_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			tbl_bytes.push_back(w[8*i +: 8]);
	endtask

	task automatic pad_to(input int start, input int len);
		while (tbl_bytes.size() - start < len)
			tbl_bytes.push_back(8'($urandom));
	endtask

	task automatic put_header(input logic [31:0] base, input logic [31:0] flags);
		put_word(base);
		put_word(flags);
	endtask

	task automatic put_raw(input logic [7:0] code, input int len);
		int start;
		start = tbl_bytes.size();
		tbl_bytes.push_back(code);
		tbl_bytes.push_back(8'(len));
		pad_to(start, len);
	endtask

	task automatic put_cpu(input int len, input logic [7:0] id, input logic [7:0] uid,
	                       input logic [31:0] flags);
		int start;
		start = tbl_bytes.size();
		tbl_bytes.push_back(REC_LAPIC);
		tbl_bytes.push_back(8'(len));
		tbl_bytes.push_back(uid);
		tbl_bytes.push_back(id);
		put_word(flags);
		pad_to(start, len);
	endtask

	task automatic put_x2cpu(input int len, input logic [31:0] id, input logic [31:0] uid,
	                         input logic [31:0] flags);
		int start;
		start = tbl_bytes.size();
		tbl_bytes.push_back(REC_X2APIC);
		tbl_bytes.push_back(8'(len));
		tbl_bytes.push_back(8'($urandom));
		tbl_bytes.push_back(8'($urandom));
		put_word(id);
		put_word(flags);
		put_word(uid);
		pad_to(start, len);
	endtask

	task automatic put_ioctl(input int len, input logic [7:0] id, input logic [31:0] addr,
	                         input logic [31:0] irq_base);
		int start;
		start = tbl_bytes.size();
		tbl_bytes.push_back(REC_IOAPIC);
		tbl_bytes.push_back(8'(len));
		tbl_bytes.push_back(id);
		tbl_bytes.push_back(8'($urandom));
		put_word(addr);
		put_word(irq_base);
		pad_to(start, len);
	endtask

	task automatic put_base(input int len, input logic [63:0] base);
		int start;
		start = tbl_bytes.size();
		tbl_bytes.push_back(REC_BASE_OVR);
		tbl_bytes.push_back(8'(len));
		tbl_bytes.push_back(8'($urandom));
		tbl_bytes.push_back(8'($urandom));
		put_word(base[31:0]);
		put_word(base[63:32]);
		pad_to(start, len);
	endtask

	// Recognised records are mostly at their minimum length; now and then
	// they run longer so that extra bytes (past the kept sixteen for x2APIC) are counted.
	function automatic int stretch_len(int min_len);
		return ($urandom_range(0, 4) == 0) ? min_len + $urandom_range(1, 8) : min_len;
	endfunction

	task automatic put_random_record();
		int          pick;
		logic [31:0] cpu_flags;
		pick      = $urandom_range(0, 99);
		cpu_flags = ($urandom_range(0, 6) == 0) ? ($urandom & 32'hFFFF_FFFE) : ($urandom | 32'h1);
		// Ids come from a small pool so that repeats are common.
		if (pick < 35) begin
			put_cpu(stretch_len(LEN_LAPIC), 8'($urandom_range(0, 15)), 8'($urandom), cpu_flags);
		end else if (pick < 50) begin
			put_x2cpu(stretch_len(LEN_X2APIC),
			          $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom,
			          $urandom, cpu_flags);
		end else if (pick < 68) begin
			put_ioctl($urandom_range(LEN_IOAPIC, LEN_IOAPIC + 2), 8'($urandom), $urandom,
			          $urandom);
		end else if (pick < 76) begin
			put_base($urandom_range(LEN_BASE, LEN_BASE + 4),
			         ($urandom_range(0, 9) == 0) ? 64'h0 : {$urandom, $urandom});
		end else if (pick < 86) begin
			case ($urandom_range(0, 3))
				0:       put_raw(REC_LAPIC, $urandom_range(LEN_MIN, LEN_LAPIC - 1));
				1:       put_raw(REC_IOAPIC, $urandom_range(LEN_MIN, LEN_IOAPIC - 1));
				2:       put_raw(REC_BASE_OVR, $urandom_range(LEN_MIN, LEN_BASE - 1));
				default: put_raw(REC_X2APIC, $urandom_range(LEN_MIN, LEN_X2APIC - 1));
			endcase
		end else begin
			put_raw(8'($urandom),
			        ($urandom_range(0, 19) == 0) ? $urandom_range(40, 64) : $urandom_range(2, 24));
		end
	endtask

	// Most tables are well formed; the rest end inside a record, carry a bad
	// length byte (followed by bytes that must be ignored) or stop within the
	// header.
	task automatic build_random_table();
		int shape;
		int nrec;
		int start;
		int len;
		put_header(($urandom_range(0, 9) == 0) ? 32'h0 : $urandom, $urandom);
		shape = $urandom_range(0, 99);
		nrec  = $urandom_range(0, 8);
		for (int i = 0; i < nrec; i++)
			put_random_record();
		if (shape >= 93) begin
			tbl_bytes.delete();
			repeat ($urandom_range(1, HDR_BYTES - 1))
				tbl_bytes.push_back(8'($urandom));
		end else if (shape >= 85) begin
			put_raw(8'($urandom), $urandom_range(0, LEN_MIN - 1));
			repeat ($urandom_range(0, 6))
				tbl_bytes.push_back(8'($urandom));
		end else if (shape >= 75) begin
			start = tbl_bytes.size();
			put_random_record();
			len = tbl_bytes.size() - start;
			repeat ($urandom_range(1, len - 1))
				void'(tbl_bytes.pop_back());
		end
	endtask

	// Tables that stop within the header, and one that is nothing but header.
	task automatic test_header_cases();
		tx_mode = IDLE_FULL;
		rx_mode = IDLE_FULL;
		tbl_bytes = '{8'hFF, 8'h00, 8'hA5};
		send_table();
		put_header(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_table();
		wait_drained();
	endtask

	// Enabled, disabled and repeated processors of both record types, id and
	// uid extremes, an over-long record, and a record ending on the final
	// byte so that its entry and the summary share one byte.
	task automatic test_processors();
		tx_mode = IDLE_FULL;
		rx_mode = IDLE_SPARSE;
		put_header(32'hFEE0_0000, 32'h0000_0001);
		put_cpu(LEN_LAPIC, 8'h00, 8'h00, 32'h0000_0001);
		put_cpu(LEN_LAPIC, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
		put_cpu(LEN_LAPIC, 8'h05, 8'h05, 32'hFFFF_FFFE);
		put_cpu(LEN_LAPIC, 8'hFF, 8'h01, 32'h0000_0001);
		put_x2cpu(LEN_X2APIC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
		put_x2cpu(LEN_X2APIC, 32'h0000_00FF, 32'h0, 32'h0000_0001);
		put_x2cpu(LEN_X2APIC + 4, 32'h1234_5678, 32'h9ABC_DEF0, 32'h8000_0001);
		send_table();
		wait_drained();
	endtask

	// I/O controllers, base replacement, short recognised records and the
	// shortest legal record.
	task automatic test_other_records();
		tx_mode = IDLE_SPARSE;
		rx_mode = IDLE_FULL;
		put_header(32'h0, 32'h0);
		put_ioctl(LEN_IOAPIC, 8'h00, 32'h0, 32'h0);
		put_ioctl(LEN_IOAPIC, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		put_raw(REC_LAPIC, LEN_LAPIC - 1);
		put_raw(REC_X2APIC, LEN_X2APIC - 1);
		put_raw(REC_IOAPIC, LEN_IOAPIC - 1);
		put_raw(REC_BASE_OVR, LEN_BASE - 1);
		put_raw(8'hFF, LEN_MIN);
		put_base(LEN_BASE + 2, 64'h0);
		put_cpu(LEN_LAPIC, 8'h01, 8'h01, 32'h0000_0001);
		put_base(LEN_BASE, 64'hFFFF_FFFF_0000_0000);
		send_table();
		wait_drained();
	endtask

	// A length byte below the minimum: later bytes are ignored, entries
	// already given stand.
	task automatic test_bad_length();
		tx_mode = IDLE_FULL;
		rx_mode = IDLE_FULL;
		put_header(32'h0000_0001, 32'h0);
		put_cpu(LEN_LAPIC, 8'h03, 8'h03, 32'h0000_0001);
		put_raw(REC_IOAPIC, 1);
		put_ioctl(LEN_IOAPIC, 8'h07, $urandom, $urandom);
		send_table();
		put_header(32'h0000_0001, 32'h0);
		put_raw(REC_LAPIC, 0);
		send_table();
		wait_drained();
	endtask

	// The table ends on a type byte, and inside the body of a record.
	task automatic test_overrun();
		tx_mode = IDLE_SPARSE;
		rx_mode = IDLE_SPARSE;
		put_header(32'hFEE0_0000, 32'h0);
		put_cpu(LEN_LAPIC, 8'h02, 8'h02, 32'h0000_0001);
		tbl_bytes.push_back(REC_LAPIC);
		send_table();
		put_header(32'hFEE0_0000, 32'h0);
		put_x2cpu(LEN_X2APIC, 32'h0000_0042, 32'h1, 32'h0000_0001);
		repeat (5) void'(tbl_bytes.pop_back());
		send_table();
		wait_drained();
	endtask

	// Fills the processor store, then offers a new id and a repeat that must
	// both be dropped, and one I/O controller more than the limit.
	task automatic test_full_store();
		tx_mode = IDLE_NONE;
		rx_mode = IDLE_SPARSE;
		put_header(32'hFEE0_0000, 32'h0000_0001);
		// Stepping by an odd number gives distinct byte-wide ids.
		for (int i = 0; i < MAX_PROCESSORS; i++)
			put_cpu(LEN_LAPIC, 8'(i * 37), 8'($urandom), 32'h0000_0001);
		put_cpu(LEN_LAPIC, 8'(MAX_PROCESSORS * 37), 8'h00, 32'h0000_0001);
		put_x2cpu(LEN_X2APIC, 32'h0, 32'h0, 32'h0000_0001);
		for (int i = 0; i <= MAX_IO_CONTROLLERS; i++)
			put_ioctl(LEN_IOAPIC, 8'(i), $urandom, $urandom);
		send_table();
		wait_drained();
	endtask

	// The sink stops for a long stretch while bytes keep coming, so the
	// output register fills and the parser has to refuse input.
	task automatic test_backpressure();
		tx_mode     = IDLE_NONE;
		rx_mode     = IDLE_NONE;
		rx_hold_req = 400;
		put_header(32'h0000_1000, $urandom);
		for (int i = 0; i < 6; i++) begin
			put_ioctl(LEN_IOAPIC, 8'(i), $urandom, $urandom);
			put_cpu(LEN_LAPIC, 8'(i), 8'(i), 32'h0000_0001);
		end
		send_table();
		wait_drained();
	endtask

	// Random tables, often back to back so that a new table follows a
	// summary at once; sometimes the sender waits for the sink to catch up.
	task automatic test_random_tables();
		int sent;
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			tx_mode = idle_mode_e'($urandom_range(0, 2));
			rx_mode = idle_mode_e'($urandom_range(0, 2));
			build_random_table();
			sent += tbl_bytes.size();
			send_table();
			if ($urandom_range(0, 3) == 0)
				wait_drained();
		end
	endtask

	// Sink: after each beat it draws a stall for the next entry; a long hold
	// asked for by a test overrides that draw.
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (result_taken) begin
				result_taken = 1'b0;
				stall = draw_wait(rx_mode);
			end
			if (rx_hold_req > 0) begin
				stall = rx_hold_req;
				rx_hold_req = 0;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Every entry beat is compared with the oldest prediction.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			result_taken = 1'b1;
			if (results_due.size() == 0) begin
				$error("entry of kind %0d arrived with nothing predicted", m_axis_tuser);
				mismatches++;
			end else begin
				want = results_due.pop_front();
				check_field("kind", want.kind, m_axis_tuser);
				check_field("proc_id", want.proc_id, m_axis_tdata[31:0]);
				check_field("proc_uid", want.proc_uid, m_axis_tdata[63:32]);
				check_field("wide_mode", want.wide_mode, m_axis_tdata[64]);
				check_field("base_address", want.base_address, m_axis_tdata[128:65]);
				check_field("first_irq_line", want.first_irq_line, m_axis_tdata[160:129]);
				check_field("table_flags", want.table_flags, m_axis_tdata[192:161]);
				check_field("proc_total", want.proc_total, m_axis_tdata[199:193]);
				check_field("table_ok", want.table_ok, m_axis_tdata[200]);
				check_field("last", want.last, m_axis_tlast);
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("madt_record_parser regression: fail");
		$finish;
	end

	initial begin
		clear_parse_state();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_header_cases();
		test_processors();
		test_other_records();
		test_bad_length();
		test_overrun();
		test_full_store();
		test_backpressure();
		test_random_tables();
		wait_drained();
		// Room for any stray entry to show itself.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("madt_record_parser regression: pass");
		else
			$display("madt_record_parser regression: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/mrp_pkg.sv
rtl/core/mrp_datapath.sv
rtl/core/mrp_ctrl.sv
rtl/core/madt_record_parser.sv
verif/tb.sv
